[design/flr_pkg.sv]
// Shared types and constants of the release list: field types, command codes
// and sequencer states.
// No dependencies; compile first.
`default_nettype none

package flr_pkg;

	localparam int unsigned CMD_W   = 3;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned COUNT_W = 7;

	typedef logic [CMD_W-1:0]   command_t;
	typedef logic [IDX_W-1:0]   index_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam command_t CMD_INSERT      = command_t'(0);
	localparam command_t CMD_REMOVE      = command_t'(1);
	localparam command_t CMD_REMOVE_HEAD = command_t'(2);
	localparam command_t CMD_REMOVE_TAIL = command_t'(3);
	localparam command_t CMD_TOUCH       = command_t'(4);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_LINK,
		ST_PUT
	} state_t;

endpackage

`default_nettype wire

[design/flr_if.sv]
// Channel interfaces of the release list: request, response and mode write.
// Depends on flr_pkg.
`default_nettype none

interface flr_req_if import flr_pkg::*; ();
	logic     valid;
	logic     ready;
	command_t command;
	index_t   entry_index;

	modport source (output valid, command, entry_index, input ready);
	modport sink (input valid, command, entry_index, output ready);
endinterface

interface flr_rsp_if import flr_pkg::*; ();
	logic   valid;
	logic   ready;
	index_t removed_entry;
	logic   removed_valid;
	logic   error;
	count_t count;

	modport source (output valid, removed_entry, removed_valid, error, count, input ready);
	modport sink (input valid, removed_entry, removed_valid, error, count, output ready);
endinterface

interface flr_cfg_if;
	logic valid;
	logic ready;
	logic lru_mode;

	modport source (output valid, lru_mode, input ready);
	modport sink (input valid, lru_mode, output ready);
endinterface

`default_nettype wire

[design/flr_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module flr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[design/fifo_lru_release_list.sv]
// Release list top level: link memories, sequencer, head/tail/count registers.
// Depends on flr_pkg, flr_if (flr_req_if, flr_rsp_if, flr_cfg_if) and flr_ram.
`default_nettype none

// Keeps entry indices as a doubly linked list in two RAMs: one holds the
// previous link of each entry, the other the next link plus the membership
// bit. After reset the block sweeps the membership RAM clear and takes no
// request until that is done (mode writes are taken at any time). The
// entry's links are read at the edge that accepts a request, the list is
// updated in ST_LOOK and the result is registered in ST_PUT; a remove or
// touch that unlinks an entry from the middle of the list passes through
// ST_LINK between the two, since the neighbor links and the entry's own
// links go through the single write port of each RAM in two turns. A new
// request is accepted only in ST_IDLE, which follows ST_PUT once the
// result is registered; the result register holds the result until the
// consumer takes it, and a consumer that holds off stalls the next request
// in the present step.
module fifo_lru_release_list
	import flr_pkg::*;
#(
	parameter int ENTRIES = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	flr_req_if.sink   req,
	flr_rsp_if.source rsp,
	flr_cfg_if.sink   cfg
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	typedef logic [IW-1:0] ent_t;

	state_t state_q, state_d;

	ent_t          head_q, tail_q;
	logic [CW-1:0] count_q;
	ent_t          clr_q;
	logic          lru_q;

	command_t cmd_s1;
	ent_t     e_s1;
	logic     in_range_s1;

	// second write turn
	ent_t      p2_next_a_s2, p2_prev_a_s2, p2_prev_d_s2;
	logic [IW:0] p2_next_d_s2;

	logic   rsp_valid_q;
	index_t rsp_removed_q;
	logic   rsp_rvalid_q, rsp_error_q;
	count_t rsp_count_q;

	logic   res_rvalid_s1, res_error_s1;
	ent_t   res_removed_s1;

	// RAM ports
	logic        next_we, prev_we;
	ent_t        next_wa, prev_wa, prev_wd, rd_a;
	logic [IW:0] next_wd, next_rd;
	ent_t        prev_rd;

	// request decode
	logic req_acc;
	logic in_range_in;
	ent_t e_in;

	// decision in ST_LOOK
	logic mem_e, at_head, at_tail, single, middle;
	logic do_ins, do_unl, do_touch, err, pop_ok, need_p2, rsp_free;
	ent_t nxt_e;

	flr_ram #(.WIDTH(IW + 1), .DEPTH(ENTRIES)) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_wa),
		.wdata (next_wd),
		.raddr (rd_a),
		.rdata (next_rd)
	);

	flr_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_prev_ram (
		.clk   (clk),
		.we    (prev_we),
		.waddr (prev_wa),
		.wdata (prev_wd),
		.raddr (rd_a),
		.rdata (prev_rd)
	);

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;

	assign in_range_in = 32'(req.entry_index) < 32'(ENTRIES);
	assign e_in        = in_range_in ? IW'(req.entry_index) : '0;

	always_comb begin
		case (req.command)
			CMD_REMOVE_HEAD: rd_a = head_q;
			CMD_REMOVE_TAIL: rd_a = tail_q;
			default:         rd_a = e_in;
		endcase
	end

	assign mem_e    = next_rd[IW] && in_range_s1;
	assign nxt_e    = next_rd[IW-1:0];
	assign at_head  = (e_s1 == head_q);
	assign at_tail  = (e_s1 == tail_q);
	assign single   = (count_q <= CW'(1));
	assign middle   = !single && !at_head && !at_tail;
	assign rsp_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		pop_ok   = 1'b0;
		do_ins   = 1'b0;
		do_unl   = 1'b0;
		do_touch = 1'b0;
		err      = 1'b0;
		case (cmd_s1)
			CMD_INSERT: begin
				err    = !in_range_s1 || mem_e;
				do_ins = !err;
			end
			CMD_REMOVE: begin
				err    = !mem_e;
				do_unl = !err;
			end
			CMD_REMOVE_HEAD, CMD_REMOVE_TAIL: begin
				pop_ok = (count_q != '0);
				do_unl = pop_ok;
			end
			CMD_TOUCH: begin
				if (lru_q) begin
					err      = !mem_e;
					do_touch = mem_e && !at_head;
				end
			end
			default: begin
			end
		endcase
		need_p2 = (do_unl || do_touch) && middle;
	end

	// next state and RAM write ports
	always_comb begin
		state_d = state_q;
		next_we = 1'b0;
		next_wa = e_s1;
		next_wd = {1'b1, head_q};
		prev_we = 1'b0;
		prev_wa = head_q;
		prev_wd = e_s1;
		case (state_q)
			ST_CLEAR: begin
				next_we = 1'b1;
				next_wa = clr_q;
				next_wd = '0;
				if (clr_q == ent_t'(ENTRIES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_acc) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (do_ins) begin
					next_we = 1'b1;
					prev_we = (count_q != '0);
				end else if (do_unl) begin
					// drop membership; neighbors of a middle entry are relinked in the next turn
					next_we = 1'b1;
					next_wd = '0;
				end else if (do_touch) begin
					next_we = 1'b1;
					prev_we = 1'b1;
					if (middle) begin
						next_wa = prev_rd;
						next_wd = {1'b1, nxt_e};
						prev_wa = nxt_e;
						prev_wd = prev_rd;
					end
				end
				state_d = need_p2 ? ST_LINK : ST_PUT;
			end
			ST_LINK: begin
				next_we = 1'b1;
				next_wa = p2_next_a_s2;
				next_wd = p2_next_d_s2;
				prev_we = 1'b1;
				prev_wa = p2_prev_a_s2;
				prev_wd = p2_prev_d_s2;
				state_d = ST_PUT;
			end
			ST_PUT: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			lru_q       <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				lru_q <= cfg.lru_mode;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ent_t'(1);
			end
			if (state_q == ST_LOOK) begin
				if (do_ins) begin
					head_q  <= e_s1;
					if (count_q == '0) begin
						tail_q <= e_s1;
					end
					count_q <= count_q + CW'(1);
				end else if (do_unl) begin
					if (!single && at_head) begin
						head_q <= nxt_e;
					end else if (!single && at_tail) begin
						tail_q <= prev_rd;
					end
					count_q <= count_q - CW'(1);
				end else if (do_touch) begin
					head_q <= e_s1;
					if (at_tail) begin
						tail_q <= prev_rd;
					end
				end
			end
			if (state_q == ST_PUT && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_s1      <= req.command;
			e_s1        <= rd_a;
			in_range_s1 <= in_range_in;
		end
		if (state_q == ST_LOOK) begin
			res_removed_s1 <= pop_ok ? e_s1 : '0;
			res_rvalid_s1  <= pop_ok;
			res_error_s1   <= err;
			if (do_touch) begin
				p2_next_a_s2 <= e_s1;
				p2_next_d_s2 <= {1'b1, head_q};
				p2_prev_a_s2 <= head_q;
				p2_prev_d_s2 <= e_s1;
			end else begin
				p2_next_a_s2 <= prev_rd;
				p2_next_d_s2 <= {1'b1, nxt_e};
				p2_prev_a_s2 <= nxt_e;
				p2_prev_d_s2 <= prev_rd;
			end
		end
		if (state_q == ST_PUT && rsp_free) begin
			rsp_removed_q <= IDX_W'(res_removed_s1);
			rsp_rvalid_q  <= res_rvalid_s1;
			rsp_error_q   <= res_error_s1;
			rsp_count_q   <= COUNT_W'(count_q);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.removed_entry = rsp_removed_q;
	assign rsp.removed_valid = rsp_rvalid_q;
	assign rsp.error         = rsp_error_q;
	assign rsp.count         = rsp_count_q;

endmodule

`default_nettype wire

[tb/sv/fifo_lru_release_list_test.sv]
// Testbench of the release list: random and directed requests against an in-bench
// linked-list predictor, with handshake idling on both channels and mode writes.
// Depends on flr_pkg, flr_if and the fifo_lru_release_list design files.
`default_nettype none

module fifo_lru_release_list_test;
	import flr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES = 64;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		command_t command;
		index_t   entry_index;
	} request_t;

	typedef struct packed {
		index_t removed_entry;
		logic   removed_valid;
		logic   error;
		count_t count;
	} list_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	flr_req_if req ();
	flr_rsp_if rsp ();
	flr_cfg_if cfg ();

	fifo_lru_release_list #(
		.ENTRIES(ENTRIES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	always #1 clk = ~clk;

	// Predicted list state, updated as requests are accepted.
	index_t          prev_link [ENTRIES];
	index_t          next_link [ENTRIES];
	logic [ENTRIES-1:0] on_list = '0;
	index_t          head_q = '0;
	index_t          tail_q = '0;
	count_t          list_count = '0;
	logic            lru_mode_q = 1'b1;

	// Generation-side view of the list order (front is head), used to build
	// well-formed requests ahead of time.
	index_t          gen_order [$];
	logic [ENTRIES-1:0] gen_member = '0;
	logic            gen_lru = 1'b1;

	request_t  pending [$];
	list_rsp_t expected_rsp [$];

	int   send_idle_pct = 38;
	int   recv_idle_pct = 85;
	logic req_fired = 1'b0;
	logic rsp_hold = 1'b0;
	logic hold_go = 1'b0;
	int   mismatch_count = 0;
	int   cycle_count = 0;

	function automatic void link_front(index_t e);
		if (list_count != 0) begin
			next_link[e] = head_q;
			prev_link[head_q] = e;
		end else begin
			tail_q = e;
		end
		head_q = e;
		on_list[e] = 1'b1;
		list_count = list_count + 1'b1;
	endfunction

	function automatic void unlink(index_t e);
		if (list_count > 1) begin
			if (e == head_q) begin
				head_q = next_link[e];
			end else if (e == tail_q) begin
				tail_q = prev_link[e];
			end else begin
				next_link[prev_link[e]] = next_link[e];
				prev_link[next_link[e]] = prev_link[e];
			end
		end
		on_list[e] = 1'b0;
		list_count = list_count - 1'b1;
	endfunction

	function automatic list_rsp_t apply_request(command_t c, index_t i);
		list_rsp_t r;
		r = '0;
		case (c)
			CMD_INSERT: begin
				if (on_list[i])
					r.error = 1'b1;
				else
					link_front(i);
			end
			CMD_REMOVE: begin
				if (!on_list[i])
					r.error = 1'b1;
				else
					unlink(i);
			end
			CMD_REMOVE_HEAD, CMD_REMOVE_TAIL: begin
				if (list_count != 0) begin
					r.removed_entry = (c == CMD_REMOVE_HEAD) ? head_q : tail_q;
					r.removed_valid = 1'b1;
					unlink(r.removed_entry);
				end
			end
			CMD_TOUCH: begin
				// FIFO mode ignores touch regardless of membership.
				if (lru_mode_q) begin
					if (!on_list[i]) begin
						r.error = 1'b1;
					end else if (i != head_q) begin
						unlink(i);
						link_front(i);
					end
				end
			end
			default: ;
		endcase
		r.count = list_count;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Sample handshakes, predict accepted requests, check responses.
	always @(posedge clk) begin
		list_rsp_t want;
		if (!arst_n) begin
			req_fired <= 1'b0;
		end else begin
			req_fired <= req.valid && req.ready;
			if (cfg.valid && cfg.ready)
				lru_mode_q = cfg.lru_mode;
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					$error("unexpected response: entry %0d valid %0b error %0b count %0d",
						rsp.removed_entry, rsp.removed_valid, rsp.error, rsp.count);
					mismatch_count++;
				end else begin
					want = expected_rsp.pop_front();
					check_field("removed_entry", want.removed_entry, rsp.removed_entry);
					check_field("removed_valid", want.removed_valid, rsp.removed_valid);
					check_field("error", want.error, rsp.error);
					check_field("count", want.count, rsp.count);
				end
			end
			if (req.valid && req.ready)
				expected_rsp.push_back(apply_request(req.command, req.entry_index));
		end
	end

	// Request driver: advance past an accepted request, then offer the next one or idle.
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req_fired)
				void'(pending.pop_front());
			if (!req.valid || req_fired) begin
				if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req.valid <= 1'b1;
					req.command <= pending[0].command;
					req.entry_index <= pending[0].entry_index;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk)
		rsp.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);

	// Long response stall so the block backs up and drops its request ready.
	initial begin
		wait (hold_go);
		@(negedge clk);
		rsp_hold <= 1'b1;
		repeat (150) @(negedge clk);
		rsp_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic void drop_from_order(index_t e);
		for (int k = 0; k < gen_order.size(); k++) begin
			if (gen_order[k] == e) begin
				gen_order.delete(k);
				break;
			end
		end
		gen_member[e] = 1'b0;
	endfunction

	function automatic void queue_request(command_t c, index_t i);
		request_t item;
		item.command = c;
		item.entry_index = i;
		pending.push_back(item);
		case (c)
			CMD_INSERT: begin
				if (!gen_member[i]) begin
					gen_order.push_front(i);
					gen_member[i] = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (gen_member[i])
					drop_from_order(i);
			end
			CMD_REMOVE_HEAD: begin
				if (gen_order.size() != 0)
					drop_from_order(gen_order[0]);
			end
			CMD_REMOVE_TAIL: begin
				if (gen_order.size() != 0)
					drop_from_order(gen_order[gen_order.size()-1]);
			end
			CMD_TOUCH: begin
				if (gen_lru && gen_member[i]) begin
					drop_from_order(i);
					gen_order.push_front(i);
					gen_member[i] = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic index_t any_index();
		return index_t'($urandom_range(ENTRIES-1));
	endfunction

	function automatic index_t pick_member();
		return gen_order[$urandom_range(gen_order.size()-1)];
	endfunction

	// Caller makes sure the list is not full.
	function automatic index_t pick_free();
		index_t e;
		do
			e = any_index();
		while (gen_member[e]);
		return e;
	endfunction

	function automatic void queue_random(int n, int insert_pct);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < insert_pct) begin
				if (gen_order.size() < ENTRIES)
					queue_request(CMD_INSERT, pick_free());
				else
					queue_request(CMD_INSERT, any_index());
			end else begin
				r = $urandom_range(99);
				if (r < 25) begin
					if (gen_order.size() != 0)
						queue_request(CMD_REMOVE, pick_member());
					else
						queue_request(CMD_REMOVE_HEAD, any_index());
				end else if (r < 45) begin
					queue_request(CMD_REMOVE_HEAD, any_index());
				end else if (r < 65) begin
					queue_request(CMD_REMOVE_TAIL, any_index());
				end else if (r < 85) begin
					if (gen_order.size() != 0)
						queue_request(CMD_TOUCH, pick_member());
					else
						queue_request(CMD_TOUCH, any_index());
				end else if (r < 96) begin
					// Noise: any legal command on any slot, errors included.
					queue_request(command_t'($urandom_range(int'(CMD_TOUCH))), any_index());
				end else begin
					queue_request(command_t'($urandom_range((1 << CMD_W) - 1,
						int'(CMD_TOUCH) + 1)), any_index());
				end
			end
		end
	endfunction

	task automatic write_mode(logic m);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.lru_mode <= m;
		do
			@(posedge clk);
		while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
		gen_lru = m;
	endtask

	task automatic wait_drained();
		while (pending.size() != 0 || expected_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.command = CMD_INSERT;
		req.entry_index = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.lru_mode = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// LRU mode: empty pops, misses, both index extremes, touches of every position.
		write_mode(1'b1);
		send_idle_pct = 38;
		recv_idle_pct = 85;
		queue_request(CMD_REMOVE_HEAD, 6'd63);
		queue_request(CMD_REMOVE_TAIL, 6'd0);
		queue_request(CMD_REMOVE, 6'd5);
		queue_request(CMD_TOUCH, 6'd5);
		queue_request(CMD_INSERT, 6'd0);
		queue_request(CMD_INSERT, 6'd63);
		queue_request(CMD_INSERT, 6'd0);
		queue_request(CMD_INSERT, 6'd21);
		queue_request(CMD_INSERT, 6'd42);
		queue_request(CMD_TOUCH, 6'd42);
		queue_request(CMD_TOUCH, 6'd0);
		queue_request(CMD_TOUCH, 6'd21);
		queue_request(CMD_REMOVE, 6'd42);
		queue_request(CMD_REMOVE, 6'd21);
		queue_request(CMD_REMOVE_TAIL, 6'd0);
		queue_request(CMD_REMOVE_HEAD, 6'd0);
		queue_request(command_t'(5), 6'd63);
		queue_request(command_t'(6), 6'd0);
		queue_request(command_t'(7), 6'd42);
		// Fill toward a full list, then churn.
		queue_random(130, 75);
		queue_random(60, 35);
		wait_drained();

		// FIFO mode: touch never errors and never reorders.
		write_mode(1'b0);
		send_idle_pct = 85;
		recv_idle_pct = 38;
		if (gen_order.size() < ENTRIES)
			queue_request(CMD_TOUCH, pick_free());
		if (gen_order.size() != 0)
			queue_request(CMD_TOUCH, pick_member());
		queue_random(120, 40);
		wait_drained();

		write_mode(1'b1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_go = 1'b1;
		queue_random(140, 45);
		wait_drained();

		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
design/flr_pkg.sv
design/flr_if.sv
design/flr_ram.sv
design/fifo_lru_release_list.sv
tb/sv/fifo_lru_release_list_test.sv
